[rtl/core/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg: shared types, constants and helpers
// Register indexes, sequencer states, arctangent table and pulse clamp for the
// servo pulse controller.
// ----------------------------------------------------------------------------
package spc_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_THROTTLE_GAIN = 3'd0;
   localparam logic [2:0] REG_STEER_GAIN    = 3'd1;
   localparam logic [2:0] REG_WHEELBASE     = 3'd2;
   localparam logic [2:0] REG_THROTTLE_MIN  = 3'd3;
   localparam logic [2:0] REG_THROTTLE_MAX  = 3'd4;
   localparam logic [2:0] REG_STEER_MIN     = 3'd5;
   localparam logic [2:0] REG_STEER_MAX     = 3'd6;

   // datapath widths
   localparam int XY_W  = 36;
   localparam int Z_W   = 32;
   localparam int ACC_W = 20;

   // 1500 us in q12.8
   localparam logic signed [39:0] CENTER_Q8 = 40'sd384000;
   localparam logic [ACC_W-1:0]   CENTER_ACC = 20'd384000;

   // zero speed saturation marks
   localparam logic signed [39:0] SAT_POS = 40'sd2147483647;
   localparam logic signed [39:0] SAT_NEG = -40'sd2147483648;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_PULSE,
      ST_MUL,
      ST_DONE
   } state_type;

   // atan(2^-i) as pulse microseconds in q.16
   function automatic logic [26:0] atan_us(input logic [4:0] idx);
      logic [26:0] r;
      case (idx)
         5'd0:    r = 27'd49152000;
         5'd1:    r = 27'd29016120;
         5'd2:    r = 27'd15331321;
         5'd3:    r = 27'd7782418;
         5'd4:    r = 27'd3906311;
         5'd5:    r = 27'd1955060;
         5'd6:    r = 27'd977768;
         5'd7:    r = 27'd488914;
         5'd8:    r = 27'd244461;
         5'd9:    r = 27'd122231;
         5'd10:   r = 27'd61116;
         5'd11:   r = 27'd30558;
         5'd12:   r = 27'd15279;
         5'd13:   r = 27'd7640;
         5'd14:   r = 27'd3820;
         5'd15:   r = 27'd1910;
         5'd16:   r = 27'd955;
         5'd17:   r = 27'd477;
         5'd18:   r = 27'd239;
         5'd19:   r = 27'd119;
         5'd20:   r = 27'd60;
         5'd21:   r = 27'd30;
         5'd22:   r = 27'd15;
         5'd23:   r = 27'd7;
         default: r = 27'd0;
      endcase
      return r;
   endfunction

   // clamp a q12.8 value: above max gives max, else below min gives min
   function automatic logic [ACC_W-1:0] clamp_q8(input logic signed [39:0] p,
                                                 input logic [11:0] lo,
                                                 input logic [11:0] hi);
      logic signed [39:0] l;
      logic signed [39:0] h;
      logic signed [39:0] r;
      l = $signed({20'b0, lo, 8'b0});
      h = $signed({20'b0, hi, 8'b0});
      if (p > h) begin
         r = h;
      end else if (p < l) begin
         r = l;
      end else begin
         r = p;
      end
      return r[ACC_W-1:0];
   endfunction

endpackage

[rtl/core/spc_cordic.sv]
// ----------------------------------------------------------------------------
// spc_cordic: shared vectoring rotator
// One micro-rotation per cycle; the angle builds up in pulse microseconds.
// ----------------------------------------------------------------------------
module spc_cordic import spc_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [XY_W-1:0] x_init,
   input  logic signed [XY_W-1:0] y_init,
   output logic                  done,
   output logic signed [Z_W-1:0] angle
);

   localparam int CNT_W = $clog2(CORDIC_STEPS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

   logic signed [XY_W-1:0] x_ff;
   logic signed [XY_W-1:0] y_ff;
   logic signed [Z_W-1:0]  z_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   busy_ff;

   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic signed [Z_W-1:0]  dz;

   // shifted terms for this step
   always_comb begin
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      dz = $signed({5'b0, atan_us(5'(cnt_ff))});
   end

   assign done  = busy_ff && (cnt_ff == LAST);
   assign angle = z_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         busy_ff <= !done;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   // rotation
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x_init;
         y_ff <= y_init;
         z_ff <= '0;
      end else if (busy_ff) begin
         if (!y_ff[XY_W-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + dz;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - dz;
         end
      end
   end

endmodule

[rtl/core/servo_pulse_p_controller_unit.sv]
// ----------------------------------------------------------------------------
// servo_pulse_p_controller_unit: incremental proportional servo controller
// Maps commanded and measured speed and turn rate to steering pulses and
// steps the throttle and steering accumulators by gain times error.
// ----------------------------------------------------------------------------
//   channel   ports                    direction
//   req_      valid/ready + 4 fields   in   speeds and turn rates, q4.12
//   rsp_      valid/ready + 2 fields   out  throttle and steer pulse, us
//   csr_      we/index/wdata           in   gains, wheelbase, limits
//
// An item runs its commanded and its measured pair through the one shared
// rotator in turn; a pair whose speed is zero skips the rotator.
// Reset puts the accumulators at 1500 us and the registers at defaults.
// A result waits in the output register; a new item may be taken meanwhile,
// and its last step holds until that result has been taken.
// ----------------------------------------------------------------------------
module servo_pulse_p_controller_unit import spc_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_cmd_speed,
   input  logic signed [15:0] req_cmd_turn_rate,
   input  logic signed [15:0] req_meas_speed,
   input  logic signed [15:0] req_meas_turn_rate,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_throttle_pulse,
   output logic [11:0]        rsp_steer_pulse,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   state_type state_ff, state_in;

   logic [15:0] throttle_gain_ff, steer_gain_ff, wheelbase_ff;
   logic [11:0] throttle_min_ff, throttle_max_ff, steer_min_ff, steer_max_ff;

   logic signed [15:0] cs_ff, ct_ff, ms_ff, mt_ff;
   logic               pair_ff;
   logic [ACC_W-1:0]   cmd_p_ff, meas_p_ff;
   logic [ACC_W-1:0]   throttle_acc_ff, steer_acc_ff;
   logic signed [33:0] th_prod_ff;
   logic signed [37:0] st_prod_ff;
   logic               rsp_valid_ff;
   logic [11:0]        rsp_throttle_ff, rsp_steer_ff;

   logic                   accept;
   logic                   out_free;
   logic signed [15:0]     v_sel, w_sel;
   logic signed [16:0]     v_ext, w_ext, v_abs, w_eff;
   logic signed [33:0]     y_prod;
   logic signed [XY_W-1:0] x0, y0;
   logic                   cordic_start, cordic_done;
   logic signed [Z_W-1:0]  angle;
   logic signed [Z_W-1:0]  z_sh;
   logic signed [39:0]     p_raw;
   logic [ACC_W-1:0]       pulse;
   logic signed [16:0]     diff_t;
   logic signed [20:0]     diff_s;
   logic signed [39:0]     dt, ds, t_sum, s_sum;
   logic [ACC_W-1:0]       t_new, s_new;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // pair selection and rotator seed
   always_comb begin
      v_sel  = pair_ff ? ms_ff : cs_ff;
      w_sel  = pair_ff ? mt_ff : ct_ff;
      v_ext  = {v_sel[15], v_sel};
      w_ext  = {w_sel[15], w_sel};
      v_abs  = v_sel[15] ? -v_ext : v_ext;
      w_eff  = v_sel[15] ? -w_ext : w_ext;
      y_prod = w_eff * $signed({1'b0, wheelbase_ff});
      x0     = {7'b0, v_abs, 12'b0};
      y0     = {{(XY_W-34){y_prod[33]}}, y_prod};
   end

   // steering pulse from angle, or for zero speed saturated by turn-rate sign (centre if zero)
   always_comb begin
      z_sh = (angle + 32'sd128) >>> 8;
      if (v_sel != 16'sd0) begin
         p_raw = CENTER_Q8 + {{8{z_sh[31]}}, z_sh};
      end else if (w_sel > 16'sd0) begin
         p_raw = SAT_POS;
      end else if (w_sel < 16'sd0) begin
         p_raw = SAT_NEG;
      end else begin
         p_raw = CENTER_Q8;
      end
      pulse = clamp_q8(p_raw, steer_min_ff, steer_max_ff);
   end

   // error terms and accumulator update
   always_comb begin
      diff_t = {cs_ff[15], cs_ff} - {ms_ff[15], ms_ff};
      diff_s = $signed({1'b0, cmd_p_ff}) - $signed({1'b0, meas_p_ff});
      dt     = ($signed({{6{th_prod_ff[33]}}, th_prod_ff}) + 40'sd2048) >>> 12;
      ds     = ($signed({{2{st_prod_ff[37]}}, st_prod_ff}) + 40'sd128) >>> 8;
      t_sum  = $signed({20'b0, throttle_acc_ff}) + dt;
      s_sum  = $signed({20'b0, steer_acc_ff}) + ds;
      t_new  = clamp_q8(t_sum, throttle_min_ff, throttle_max_ff);
      s_new  = clamp_q8(s_sum, steer_min_ff, steer_max_ff);
   end

   spc_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .x_init (x0),
      .y_init (y0),
      .done   (cordic_done),
      .angle  (angle)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_LOAD;
         ST_LOAD:  state_in = (v_sel != 16'sd0) ? ST_RUN : ST_PULSE;
         ST_RUN:   if (cordic_done) state_in = ST_PULSE;
         ST_PULSE: state_in = pair_ff ? ST_MUL : ST_LOAD;
         ST_MUL:   state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      cordic_start = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready    = 1'b1;
         ST_LOAD: cordic_start = (v_sel != 16'sd0);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_gain_ff <= 16'd32000;
         steer_gain_ff    <= 16'd128;
         wheelbase_ff     <= 16'd1475;
         throttle_min_ff  <= 12'd1300;
         throttle_max_ff  <= 12'd1580;
         steer_min_ff     <= 12'd1000;
         steer_max_ff     <= 12'd2000;
      end else if (csr_we) begin
         case (csr_index)
            REG_THROTTLE_GAIN: throttle_gain_ff <= csr_wdata;
            REG_STEER_GAIN:    steer_gain_ff    <= csr_wdata;
            REG_WHEELBASE:     wheelbase_ff     <= csr_wdata;
            REG_THROTTLE_MIN:  throttle_min_ff  <= csr_wdata[11:0];
            REG_THROTTLE_MAX:  throttle_max_ff  <= csr_wdata[11:0];
            REG_STEER_MIN:     steer_min_ff     <= csr_wdata[11:0];
            REG_STEER_MAX:     steer_max_ff     <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // item capture, pulses and products
   always_ff @(posedge clock) begin
      if (accept) begin
         cs_ff <= req_cmd_speed;
         ct_ff <= req_cmd_turn_rate;
         ms_ff <= req_meas_speed;
         mt_ff <= req_meas_turn_rate;
      end
      if (state_ff == ST_PULSE) begin
         if (pair_ff) begin
            meas_p_ff <= pulse;
         end else begin
            cmd_p_ff <= pulse;
         end
      end
      if (state_ff == ST_MUL) begin
         th_prod_ff <= diff_t * $signed({1'b0, throttle_gain_ff});
         st_prod_ff <= diff_s * $signed({1'b0, steer_gain_ff});
      end
   end

   // pair flag, accumulators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff         <= 1'b0;
         throttle_acc_ff <= CENTER_ACC;
         steer_acc_ff    <= CENTER_ACC;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            pair_ff <= 1'b0;
         end else if (state_ff == ST_PULSE) begin
            pair_ff <= 1'b1;
         end
         if (state_ff == ST_DONE && out_free) begin
            throttle_acc_ff <= t_new;
            steer_acc_ff    <= s_new;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_throttle_ff <= t_new[ACC_W-1:8];
         rsp_steer_ff    <= s_new[ACC_W-1:8];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_throttle_pulse = rsp_throttle_ff;
   assign rsp_steer_pulse    = rsp_steer_ff;

endmodule

[tb/tb_servo_pulse_p_controller_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_pulse_p_controller_unit: self-checking bench for the servo unit
// Drives speed and turn-rate items through valid/ready, predicts the throttle
// and steering pulses with a local arctangent rotator and accumulator model,
// and compares every result in order. Gains, wheelbase and limits are moved
// through several settings between phases, with both sides idling at random in most phases.
// ----------------------------------------------------------------------------
module tb_servo_pulse_p_controller_unit;
   import spc_pkg::*;

   localparam int ROT_STEPS = 16;
   localparam int LIMIT_CYCLES = 1500000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_cmd_speed;
   logic signed [15:0] req_cmd_turn_rate;
   logic signed [15:0] req_meas_speed;
   logic signed [15:0] req_meas_turn_rate;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [11:0]        rsp_throttle_pulse;
   logic [11:0]        rsp_steer_pulse;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   // predictor copy of registers and accumulators
   logic [15:0] p_tgain, p_sgain, p_wbase;
   logic [11:0] p_tmin, p_tmax, p_smin, p_smax;
   logic [19:0] p_tacc, p_sacc;

   logic [11:0] pulse_q[$];
   int          errors;
   int          cycles;
   int          send_idle;
   int          recv_idle;
   int          hold_cycles;

   servo_pulse_p_controller_unit #(.CORDIC_STEPS(ROT_STEPS)) uut (.*);

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // arctangent table, pulse microseconds q.16
   function automatic longint atan_q16(input int i);
      longint t[16] = '{49152000, 29016120, 15331321, 7782418, 3906311, 1955060,
                        977768, 488914, 244461, 122231, 61116, 30558, 15279,
                        7640, 3820, 1910};
      return t[i];
   endfunction

   function automatic longint clamp_pulse(input longint p, input logic [11:0] lo,
                                          input logic [11:0] hi);
      longint l, h;
      l = longint'(lo) * 256;
      h = longint'(hi) * 256;
      if (p > h) return h;
      if (p < l) return l;
      return p;
   endfunction

   // steering pulse q12.8 from one speed and turn rate pair
   function automatic longint steer_pulse_q8(input longint v, input longint w);
      longint x, y, z, dx, dy, p;
      if (v == 0) begin
         p = (w > 0) ? 64'sd2147483647 : ((w < 0) ? -64'sd2147483648 : 64'sd384000);
      end else begin
         x = (v < 0 ? -v : v) * 4096;
         y = w * longint'(p_wbase);
         z = 0;
         if (v < 0) y = -y;
         for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += atan_q16(i);
            end else begin
               x -= dx; y += dy; z -= atan_q16(i);
            end
         end
         p = 384000 + ((z + 128) >>> 8);
      end
      return clamp_pulse(p, p_smin, p_smax);
   endfunction

   task automatic predict_pulses(input logic signed [15:0] cs, ct, ms, mt);
      longint cp, mp, dt, ds, t, s;
      cp = steer_pulse_q8(cs, ct);
      mp = steer_pulse_q8(ms, mt);
      dt = (longint'(p_tgain) * (longint'(cs) - longint'(ms)) + 2048) >>> 12;
      ds = (longint'(p_sgain) * (cp - mp) + 128) >>> 8;
      t = clamp_pulse(longint'(p_tacc) + dt, p_tmin, p_tmax);
      s = clamp_pulse(longint'(p_sacc) + ds, p_smin, p_smax);
      p_tacc = t[19:0];
      p_sacc = s[19:0];
      pulse_q.push_back(p_tacc[19:8]);
      pulse_q.push_back(p_sacc[19:8]);
   endtask

   // send one item, predicting at acceptance
   task automatic send_item(input logic signed [15:0] cs, ct, ms, mt);
      while ($urandom_range(99) < send_idle) @(posedge clock);
      req_valid          <= 1'b1;
      req_cmd_speed      <= cs;
      req_cmd_turn_rate  <= ct;
      req_meas_speed     <= ms;
      req_meas_turn_rate <= mt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pulses(cs, ct, ms, mt);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_THROTTLE_GAIN: p_tgain = val;
         REG_STEER_GAIN:    p_sgain = val;
         REG_WHEELBASE:     p_wbase = val;
         REG_THROTTLE_MIN:  p_tmin = val[11:0];
         REG_THROTTLE_MAX:  p_tmax = val[11:0];
         REG_STEER_MIN:     p_smin = val[11:0];
         REG_STEER_MAX:     p_smax = val[11:0];
         default: ;
      endcase
   endtask

   // wait until every result is back, then let the block settle
   task automatic drain;
      while (pulse_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pulse_q.size() < 2) begin
            report("unexpected item", rsp_throttle_pulse, 0);
         end else begin
            logic [11:0] tw, sw;
            tw = pulse_q.pop_front();
            sw = pulse_q.pop_front();
            if (rsp_throttle_pulse !== tw) report("throttle", rsp_throttle_pulse, tw);
            if (rsp_steer_pulse !== sw) report("steer", rsp_steer_pulse, sw);
         end
      end
   end

   function automatic logic signed [15:0] rand_field;
      case ($urandom_range(5))
         0: return 16'sd0;
         1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         2: return $signed(16'($urandom_range(8191))) - 16'sd4096;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++) send_item(rand_field(), rand_field(), rand_field(),
                                            rand_field());
   endtask

   // directed corners
   task automatic test_corners;
      send_item(0, 0, 0, 0);
      send_item(0, 4096, 0, -4096);
      send_item(0, -4096, 0, 4096);
      send_item(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
      send_item(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_item(4096, 0, -4096, 0);
      send_item(-4096, 2048, 4096, -2048);
      send_item(16'shffff, 16'sh0001, 16'sh0001, 16'shffff);
      send_item(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
      for (int i = 0; i < 6; i++) send_item(16'sh7fff, 0, 16'sh8000, 0);
      for (int i = 0; i < 6; i++) send_item(16'sh8000, 4096, 16'sh7fff, -4096);
      drain();
      // zero wheelbase, inverted limits and index beyond the list
      write_reg(REG_WHEELBASE, 16'd0);
      write_reg(REG_STEER_MIN, 16'd2500);
      write_reg(REG_STEER_MAX, 16'd900);
      write_reg(3'd7, 16'hffff);
      send_item(4096, 4096, 2048, -4096);
      send_item(0, 4096, 0, 0);
      drain();
   endtask

   // random items under one register setting
   task automatic test_setting(input logic [15:0] tg, sg, wb, tmn, tmx, smn, smx,
                               input int n);
      write_reg(REG_THROTTLE_GAIN, tg);
      write_reg(REG_STEER_GAIN, sg);
      write_reg(REG_WHEELBASE, wb);
      write_reg(REG_THROTTLE_MIN, tmn);
      write_reg(REG_THROTTLE_MAX, tmx);
      write_reg(REG_STEER_MIN, smn);
      write_reg(REG_STEER_MAX, smx);
      send_random(n);
      drain();
   endtask

   // long receiver hold-off while items keep coming
   task automatic test_backpressure;
      hold_cycles <= 400;
      send_random(8);
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd_speed = '0;
      req_cmd_turn_rate = '0;
      req_meas_speed = '0;
      req_meas_turn_rate = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      cycles = 0;
      hold_cycles = 0;
      send_idle = 28;
      recv_idle = 54;
      p_tgain = 16'd32000; p_sgain = 16'd128; p_wbase = 16'd1475;
      p_tmin = 12'd1300; p_tmax = 12'd1580; p_smin = 12'd1000; p_smax = 12'd2000;
      p_tacc = CENTER_ACC; p_sacc = CENTER_ACC;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corners();
      test_setting(16'd32000, 16'd128, 16'd1475, 16'd1300, 16'd1580, 16'd1000, 16'd2000,
                   400);
      test_backpressure();
      send_idle = 54;
      recv_idle = 28;
      test_setting(16'hffff, 16'hffff, 16'hffff, 16'd0, 16'd4095, 16'd0, 16'd4095, 400);
      test_setting(16'd0, 16'd0, 16'd1, 16'd4095, 16'd0, 16'd4095, 16'd4095, 200);
      test_setting(16'd256, 16'd256, 16'd4096, 16'd1000, 16'd2000, 16'd1100, 16'd1900,
                   400);
      send_idle = 0;
      recv_idle = 0;
      test_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'd1200, 16'd1800,
                   16'd900, 16'd2100, 600);
      test_backpressure();

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
